[design/assert_macros.svh]
// Assertion helpers shared by the record filter modules.
// Needs clk and rst to be present in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define PRLF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PRLF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/prlf_pkg.sv]
// Types, constants and the global header table of the pcap record filter.
// No dependencies; used by every module of the block.
`default_nettype none
package prlf_pkg;

  localparam int GLOBAL_LEN = 24;
  localparam int RECHDR_LEN = 16;
  localparam int POS_W      = 5;
  localparam int HDR_IDX_W  = 4;
  localparam int HDR_ADDR_W = 5;
  localparam int KEEP_W     = 19;

  localparam logic [31:0]     USEC_LIMIT = 32'd1000000;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 19'd1000;
  localparam logic [POS_W-1:0]  GLOBAL_LAST = 5'd23;
  localparam logic [HDR_IDX_W-1:0] RECHDR_LAST = 4'd15;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       format_error;
    logic       run_last;
  } result_t;

  typedef enum logic [2:0] {
    PH_GLOBAL  = 3'b001,
    PH_RECHDR  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_ERROR  = 2'd1,
    CMD_REPLAY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       bank;
  } cmd_t;

  typedef struct packed {
    logic                  en;
    logic [HDR_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } hdr_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // Expected bytes of the big-endian global header.
  function automatic logic [7:0] expected_global(input logic [POS_W-1:0] pos);
    logic [7:0] v;
    case (pos)
      5'd0:    v = 8'hA1;
      5'd1:    v = 8'hB2;
      5'd2:    v = 8'hC3;
      5'd3:    v = 8'hD4;
      5'd5:    v = 8'h02;
      5'd7:    v = 8'h04;
      5'd17:   v = 8'h04;
      5'd23:   v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[design/pcap_record_length_filter.sv]
// pcap_record_length_filter: byte-serial filter for big-endian pcap files.
// An accepted byte's result passes through the command queue and then the result register.
// Throughput: one byte per cycle in while full is low; a kept record header leaves as a burst of
// sixteen results at one per cycle while the receiver pops, from the header store's single read port.
// Reset (rst, synchronous): parser, queue and result valid flag clear, limit 1000;
// the header store keeps its contents and needs no clearing pass.
`default_nettype none
module pcap_record_length_filter #(
  parameter int CMD_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // byte input, queue style
  input  wire logic                        push,
  input  wire prlf_pkg::item_t             item,
  output logic                             full,
  // filtered output, queue style
  output logic                             empty,
  input  wire logic                        pop,
  output prlf_pkg::result_t                result,
  // length limit register
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [prlf_pkg::KEEP_W-1:0] cfg_data
);

  // Command path from the front to the back.
  logic                cmd_wr;
  prlf_pkg::cmd_t      cmd;
  logic                cmd_full;
  logic                cmd_rd;
  prlf_pkg::cmd_t      cmd_head;
  logic                cmd_empty;
  // Header store write port and bank hand-back.
  prlf_pkg::hdr_wr_t   hdr_wr;
  prlf_pkg::bank_rel_t bank_rel;

  // The limit register is always writable; it lives in the front.
  assign cfg_ready = 1'b1;

  // Front: check the global header, gather each record header into one of
  // two store banks, decide keep or drop, and queue one command per byte
  // that gives results. Hold input while the queue is full or the bank to
  // be written is still being replayed.
  prlf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd_full (cmd_full),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd),
    .hdr_wr   (hdr_wr),
    .bank_rel (bank_rel)
  );

  // Queue: decouple parsing from header replay bursts.
  prlf_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cmd_wr),
    .wr_cmd     (cmd),
    .fifo_full  (cmd_full),
    .rd_en      (cmd_rd),
    .head       (cmd_head),
    .fifo_empty (cmd_empty)
  );

  // Back: advance one result per cycle into the result register while it is empty or
  // being popped; replay a kept header byte by byte and release its bank after the sixteenth.
  prlf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .hdr_wr    (hdr_wr),
    .head      (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_rd    (cmd_rd),
    .bank_rel  (bank_rel),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire

[design/prlf_cmd_fifo.sv]
// Short command queue between the parser front and the emitter back.
// Depends on prlf_pkg for the command type.
`default_nettype none
`include "assert_macros.svh"
module prlf_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire prlf_pkg::cmd_t wr_cmd,
  output logic                fifo_full,
  input  wire logic           rd_en,
  output prlf_pkg::cmd_t      head,
  output logic                fifo_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  prlf_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign fifo_full  = (count == CNT_FULL);
  assign fifo_empty = (count == '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `PRLF_ASSERT(a_no_overflow, wr_en |-> (!fifo_full || rd_en), "command queue overflow")
  `PRLF_ASSERT(a_count_bound, count <= CNT_FULL, "command count beyond depth")

endmodule
`default_nettype wire

[design/prlf_front.sv]
// Parser front: checks headers, collects record lengths, queues commands.
// Depends on prlf_pkg; writes the header store that sits in prlf_back.
`default_nettype none
`include "assert_macros.svh"
module prlf_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire prlf_pkg::item_t                 item,
  output logic                                 full,
  input  wire logic                            cfg_wr,
  input  wire logic [prlf_pkg::KEEP_W-1:0]     cfg_data,
  input  wire logic                            cmd_full,
  output logic                                 cmd_wr,
  output prlf_pkg::cmd_t                       cmd,
  output prlf_pkg::hdr_wr_t                    hdr_wr,
  input  wire prlf_pkg::bank_rel_t             bank_rel
);

  logic [prlf_pkg::KEEP_W-1:0] max_keep_length;
  prlf_pkg::phase_t            phase, phase_next;
  logic [prlf_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic                        global_mismatch, global_mismatch_next;
  logic                        halted, halted_next;
  logic                        keep_record, keep_record_next;
  logic [31:0]                 payload_remaining, payload_remaining_next;
  logic [31:0]                 usec_acc, usec_acc_next;
  logic [31:0]                 incl_acc, incl_acc_next;
  logic [23:0]                 orig_acc, orig_acc_next;
  logic                        wbank, wbank_next;
  logic [1:0]                  bank_busy, bank_busy_next;

  logic                        accept;
  prlf_pkg::phase_t            eff_phase;
  logic [prlf_pkg::POS_W-1:0]  eff_pos;
  logic                        eff_mismatch;
  logic                        eff_halted;
  logic                        mm;
  logic [31:0]                 orig_word;
  logic [prlf_pkg::HDR_IDX_W-1:0] hidx;

  assign full   = cmd_full || bank_busy[wbank];
  assign accept = push && !full;

  always_comb begin
    eff_phase    = item.first_byte ? prlf_pkg::PH_GLOBAL : phase;
    eff_pos      = item.first_byte ? '0 : byte_position;
    eff_mismatch = item.first_byte ? 1'b0 : global_mismatch;
    eff_halted   = item.first_byte ? 1'b0 : halted;
    hidx         = eff_pos[prlf_pkg::HDR_IDX_W-1:0];
    orig_word    = {orig_acc, item.in_byte};
    mm           = eff_mismatch || (item.in_byte != prlf_pkg::expected_global(eff_pos));

    phase_next             = phase;
    byte_position_next     = byte_position;
    global_mismatch_next   = global_mismatch;
    halted_next            = halted;
    keep_record_next       = keep_record;
    payload_remaining_next = payload_remaining;
    usec_acc_next          = usec_acc;
    incl_acc_next          = incl_acc;
    orig_acc_next          = orig_acc;
    wbank_next             = wbank;
    bank_busy_next         = bank_busy;
    cmd_wr                 = 1'b0;
    cmd.kind               = prlf_pkg::CMD_BYTE;
    cmd.data               = item.in_byte;
    cmd.bank               = wbank;
    hdr_wr.en              = 1'b0;
    hdr_wr.addr            = {wbank, hidx};
    hdr_wr.data            = item.in_byte;

    if (bank_rel.valid) begin
      bank_busy_next[bank_rel.bank] = 1'b0;
    end

    if (accept) begin
      phase_next           = eff_phase;
      byte_position_next   = eff_pos;
      global_mismatch_next = eff_mismatch;
      halted_next          = eff_halted;
      if (!eff_halted) begin
        case (eff_phase)
          prlf_pkg::PH_GLOBAL: begin
            cmd_wr = 1'b1;
            global_mismatch_next = mm;
            if (eff_pos >= prlf_pkg::GLOBAL_LAST) begin
              if (mm) begin
                cmd.kind    = prlf_pkg::CMD_ERROR;
                halted_next = 1'b1;
              end else begin
                phase_next         = prlf_pkg::PH_RECHDR;
                byte_position_next = '0;
              end
            end else begin
              byte_position_next = eff_pos + 1'b1;
            end
          end
          prlf_pkg::PH_RECHDR: begin
            hdr_wr.en = 1'b1;
            if (hidx >= 4'd4 && hidx <= 4'd7) begin
              usec_acc_next = {usec_acc[23:0], item.in_byte};
            end
            if (hidx >= 4'd8 && hidx <= 4'd11) begin
              incl_acc_next = {incl_acc[23:0], item.in_byte};
            end
            if (hidx >= 4'd12 && hidx <= 4'd14) begin
              orig_acc_next = {orig_acc[15:0], item.in_byte};
            end
            if (hidx != prlf_pkg::RECHDR_LAST) begin
              byte_position_next = {1'b0, hidx + 1'b1};
            end else begin
              byte_position_next = '0;
              if (usec_acc >= prlf_pkg::USEC_LIMIT || incl_acc != orig_word) begin
                cmd_wr      = 1'b1;
                cmd.kind    = prlf_pkg::CMD_ERROR;
                halted_next = 1'b1;
              end else begin
                keep_record_next       = (orig_word <= {13'd0, max_keep_length});
                payload_remaining_next = orig_word;
                phase_next = (orig_word == '0) ? prlf_pkg::PH_RECHDR : prlf_pkg::PH_PAYLOAD;
                if (orig_word <= {13'd0, max_keep_length}) begin
                  // Hand the completed bank to the back and switch to the other one.
                  cmd_wr                = 1'b1;
                  cmd.kind              = prlf_pkg::CMD_REPLAY;
                  bank_busy_next[wbank] = 1'b1;
                  wbank_next            = !wbank;
                end
              end
            end
          end
          prlf_pkg::PH_PAYLOAD: begin
            cmd_wr = keep_record;
            payload_remaining_next = payload_remaining - 1'b1;
            if (payload_remaining <= 32'd1) begin
              payload_remaining_next = '0;
              phase_next             = prlf_pkg::PH_RECHDR;
              byte_position_next     = '0;
            end
          end
          default: begin
            phase_next = prlf_pkg::PH_GLOBAL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_keep_length   <= prlf_pkg::KEEP_RESET;
      phase             <= prlf_pkg::PH_GLOBAL;
      byte_position     <= '0;
      global_mismatch   <= 1'b0;
      halted            <= 1'b0;
      keep_record       <= 1'b0;
      payload_remaining <= '0;
      wbank             <= 1'b0;
      bank_busy         <= '0;
    end else begin
      if (cfg_wr) begin
        max_keep_length <= cfg_data;
      end
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      global_mismatch   <= global_mismatch_next;
      halted            <= halted_next;
      keep_record       <= keep_record_next;
      payload_remaining <= payload_remaining_next;
      wbank             <= wbank_next;
      bank_busy         <= bank_busy_next;
    end
  end

  always_ff @(posedge clk) begin
    usec_acc <= usec_acc_next;
    incl_acc <= incl_acc_next;
    orig_acc <= orig_acc_next;
  end

  `PRLF_ASSERT(a_wr_free_bank, hdr_wr.en |-> !bank_busy[hdr_wr.addr[prlf_pkg::HDR_ADDR_W-1]], "header write into a bank still being replayed")

endmodule
`default_nettype wire

[design/prlf_back.sv]
// Emitter back: header store, replay sequencer and the result register.
// Depends on prlf_pkg; takes commands from prlf_cmd_fifo.
`default_nettype none
`include "assert_macros.svh"
module prlf_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire prlf_pkg::hdr_wr_t    hdr_wr,
  input  wire prlf_pkg::cmd_t       head,
  input  wire logic                 cmd_empty,
  output logic                      cmd_rd,
  output prlf_pkg::bank_rel_t       bank_rel,
  output prlf_pkg::result_t         result,
  output logic                      empty,
  input  wire logic                 pop
);

  logic [7:0]                      hdr_mem [2 * prlf_pkg::RECHDR_LEN];
  logic                            out_valid;
  logic                            busy;
  logic                            bank;
  logic [prlf_pkg::HDR_IDX_W-1:0]  idx;
  logic                            can_load;
  logic                            replay_step;
  logic [prlf_pkg::HDR_ADDR_W-1:0] rd_addr;

  assign empty       = !out_valid;
  assign can_load    = !out_valid || pop;
  assign replay_step = busy && can_load;
  assign cmd_rd      = !busy && !cmd_empty && can_load;
  assign rd_addr     = busy ? {bank, idx} : {head.bank, {prlf_pkg::HDR_IDX_W{1'b0}}};

  assign bank_rel.valid = replay_step && (idx == prlf_pkg::RECHDR_LAST);
  assign bank_rel.bank  = bank;

  always_ff @(posedge clk) begin
    if (hdr_wr.en) begin
      hdr_mem[hdr_wr.addr] <= hdr_wr.data;
    end
  end

  // Result payload; header bytes come straight out of the store.
  always_ff @(posedge clk) begin
    if (replay_step) begin
      result.out_byte     <= hdr_mem[rd_addr];
      result.format_error <= 1'b0;
      result.run_last     <= (idx == prlf_pkg::RECHDR_LAST);
    end else if (cmd_rd) begin
      case (head.kind)
        prlf_pkg::CMD_REPLAY: begin
          result.out_byte     <= hdr_mem[rd_addr];
          result.format_error <= 1'b0;
          result.run_last     <= 1'b0;
        end
        prlf_pkg::CMD_ERROR: begin
          result.out_byte     <= 8'h00;
          result.format_error <= 1'b1;
          result.run_last     <= 1'b1;
        end
        default: begin
          result.out_byte     <= head.data;
          result.format_error <= 1'b0;
          result.run_last     <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      bank      <= 1'b0;
      idx       <= '0;
    end else begin
      if (replay_step) begin
        out_valid <= 1'b1;
        idx       <= idx + 1'b1;
        if (idx == prlf_pkg::RECHDR_LAST) begin
          busy <= 1'b0;
        end
      end else if (cmd_rd) begin
        out_valid <= 1'b1;
        if (head.kind == prlf_pkg::CMD_REPLAY) begin
          busy <= 1'b1;
          bank <= head.bank;
          idx  <= {{(prlf_pkg::HDR_IDX_W-1){1'b0}}, 1'b1};
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PRLF_ASSERT(a_rel_busy, bank_rel.valid |=> !busy || (bank != $past(bank)), "bank released while replay continues")

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for pcap_record_length_filter: queue-style request
// and result ports, length limit register, byte-level prediction of the output.
// Depends on prlf_pkg (item_t, result_t, phase_t, KEEP_W) and the filter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_W           = prlf_pkg::KEEP_W;
  localparam int HOLD_CYCLES       = 300;  // long receiver stall, fills the block
  localparam int SETTLE_CYCLES     = 8;    // settling time after the last expected result
  localparam int ITEMS_PER_SETTING = 19;
  localparam int SHORT_PAYLOAD     = 6;    // longer payloads get cut by a restart
  localparam int HDR_LAST          = 15;
  localparam int GHDR_LAST         = 23;
  localparam logic [31:0] USEC_MAX = 32'd999_999;
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = 19'd262144;
  localparam bit Y = 1'b1;
  localparam bit N = 1'b0;

  // One directed request: the byte, its restart mark, and, where the answer is
  // obvious, a fixed expectation that replaces the predictor's.
  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       fixed;
    logic       has_out;
    logic       err;
  } drow_t;

  logic                clk;
  logic                rst;
  logic                push;
  prlf_pkg::item_t     item;
  logic                full;
  logic                empty;
  logic                pop;
  prlf_pkg::result_t   result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_data;

  drow_t               row_now;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_asks = 0;
  int                  items_sent;
  bit                  stream_clean;
  logic [LIMIT_W-1:0]  cur_limit;

  // Counters for the summary and the verdict
  int n_fail = 0;
  int n_checked = 0;
  int n_files = 0;
  int n_records = 0;
  int n_err_expected = 0;

  // Predictor state
  prlf_pkg::phase_t    cur_phase;
  logic [4:0]          hdr_pos;
  logic [7:0]          rec_hdr [16];
  logic [31:0]         payload_left;
  bit                  keep_rec;
  bit                  ghdr_bad;
  bit                  halted;
  logic [LIMIT_W-1:0]  keep_limit;
  prlf_pkg::result_t   pending_out [$];

  // Big-endian classic capture header: magic, version 2.4, zone, sigfigs,
  // snaplen 262144, link type 1.
  logic [7:0] pcap_global [24] = '{
    8'hA1, 8'hB2, 8'hC3, 8'hD4, 8'h00, 8'h02, 8'h00, 8'h04,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};

  // Directed opening: a global header with a wrong magic byte, which passes
  // bytes through and then reports one error in place of the last byte; two
  // bytes swallowed while halted; a restart that brings the parser back.
  // Columns: byte, restart, fixed expectation, result, error.
  drow_t directed_rows [27] = '{
    '{8'hA1, Y, Y, Y, N},
    '{8'hB2, N, Y, Y, N},
    '{8'hC3, N, Y, Y, N},
    '{8'hFF, N, Y, Y, N},   // wrong magic byte, still passed through
    '{8'h00, N, Y, Y, N},
    '{8'h02, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h04, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h04, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h00, N, Y, Y, N},
    '{8'h01, N, Y, Y, Y},   // last header byte: the error takes its place
    '{8'hFF, N, Y, N, N},   // halted: swallowed
    '{8'h00, N, Y, N, N},   // halted: swallowed
    '{8'h00, Y, Y, Y, N}    // restart: treated as header byte zero
  };

  pcap_record_length_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous upper bound; a correct run finishes far sooner.
  initial begin
    #400_000;
    $display("FAIL pcap_record_length_filter");
    $finish;
  end

  // Append one expected result behind those already waiting.
  task automatic expect_result(input prlf_pkg::result_t r);
    pending_out.insert(pending_out.size(), r);
  endtask

  // Record a format error: one zero byte with the error and last flags, then halt.
  task automatic flag_format_error();
    halted = 1'b1;
    n_err_expected++;
    expect_result('{8'h00, 1'b1, 1'b1});
  endtask

  // Advance the predictor by one accepted byte and queue the results it causes.
  task automatic parse_byte(input prlf_pkg::item_t it);
    logic [4:0]  p;
    logic [31:0] usec;
    logic [31:0] incl;
    logic [31:0] orig;
    if (it.first_byte) begin
      cur_phase = prlf_pkg::PH_GLOBAL;
      hdr_pos   = '0;
      ghdr_bad  = 1'b0;
      halted    = 1'b0;
    end
    if (halted) return;
    case (cur_phase)
      prlf_pkg::PH_GLOBAL: begin
        p = (hdr_pos > GHDR_LAST) ? 5'(GHDR_LAST) : hdr_pos;
        if (it.in_byte != pcap_global[p]) ghdr_bad = 1'b1;
        if (p == GHDR_LAST) begin
          // Mismatches anywhere in the header surface only here
          if (ghdr_bad) begin
            flag_format_error();
            return;
          end
          cur_phase = prlf_pkg::PH_RECHDR;
          hdr_pos   = '0;
        end else begin
          hdr_pos = p + 5'd1;
        end
        expect_result('{it.in_byte, 1'b0, 1'b1});
      end
      prlf_pkg::PH_RECHDR: begin
        p = {1'b0, hdr_pos[3:0]};
        rec_hdr[p] = it.in_byte;
        if (p < HDR_LAST) begin
          hdr_pos = p + 5'd1;
          return;
        end
        hdr_pos = '0;
        usec = {rec_hdr[4], rec_hdr[5], rec_hdr[6], rec_hdr[7]};
        incl = {rec_hdr[8], rec_hdr[9], rec_hdr[10], rec_hdr[11]};
        orig = {rec_hdr[12], rec_hdr[13], rec_hdr[14], rec_hdr[15]};
        if (usec > USEC_MAX || incl != orig) begin
          flag_format_error();
          return;
        end
        keep_rec     = (orig <= 32'(keep_limit));
        payload_left = orig;
        // An empty record ends at its header
        cur_phase = (orig == 0) ? prlf_pkg::PH_RECHDR : prlf_pkg::PH_PAYLOAD;
        if (keep_rec)
          for (int i = 0; i <= HDR_LAST; i++)
            expect_result('{rec_hdr[i], 1'b0, i == HDR_LAST});
      end
      default: begin
        if (keep_rec) expect_result('{it.in_byte, 1'b0, 1'b1});
        if (payload_left > 0) payload_left--;
        if (payload_left == 0) begin
          cur_phase = prlf_pkg::PH_RECHDR;
          hdr_pos   = '0;
        end
      end
    endcase
  endtask

  // Compare one popped result, field by field, with the oldest expectation.
  task automatic check_result();
    prlf_pkg::result_t exp_r;
    if (pending_out.size() == 0) begin
      $display("%0t: unexpected result byte %02h err %0b last %0b", $time,
               result.out_byte, result.format_error, result.run_last);
      n_fail++;
      return;
    end
    exp_r = pending_out.pop_front();
    n_checked++;
    if (result.out_byte !== exp_r.out_byte || result.format_error !== exp_r.format_error ||
        result.run_last !== exp_r.run_last) begin
      $display("%0t: mismatch: expected byte %02h err %0b last %0b, got byte %02h err %0b last %0b",
               $time, exp_r.out_byte, exp_r.format_error, exp_r.run_last,
               result.out_byte, result.format_error, result.run_last);
      n_fail++;
    end
  endtask

  // Monitor: one process samples every handshake at the rising edge, so the
  // prediction of an accepted request always lands before its results.
  always @(posedge clk) begin
    int n0;
    if (rst) begin
      cur_phase    = prlf_pkg::PH_GLOBAL;
      hdr_pos      = '0;
      payload_left = '0;
      keep_rec     = 1'b0;
      ghdr_bad     = 1'b0;
      halted       = 1'b0;
      keep_limit   = 19'd1000;
    end else begin
      if (cfg_valid && cfg_ready) keep_limit = cfg_data;
      if (push && !full) begin
        n0 = pending_out.size();
        parse_byte(item);
        // Directed rows with a fixed answer: replace what the predictor queued
        if (row_now.fixed) begin
          while (pending_out.size() > n0) void'(pending_out.pop_back());
          if (row_now.has_out)
            expect_result('{row_now.err ? 8'h00 : row_now.b, row_now.err, 1'b1});
        end
      end
      if (pop && !empty) check_result();
    end
  end

  // Receiver: pop at random, and hold off for a long stretch on request.
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request, idling first at random; return at the accepting edge.
  // Push is left high so back-to-back requests never drop it within a step.
  task automatic send_byte(input drow_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    item    <= '{r.b, r.first};
    row_now <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // Trailing junk after a broken file; now and then it carries a restart.
  task automatic send_noise();
    repeat ($urandom_range(3))
      send_byte({8'($urandom), $urandom_range(7) == 0, 3'b000});
  endtask

  // One record header and its payload; clean tells whether the parser is left
  // waiting for the next record header, so the stream can go on without restart.
  task automatic send_record(output bit clean);
    logic [31:0]  usec;
    logic [31:0]  incl;
    logic [31:0]  orig;
    logic [127:0] rh;
    clean = 1'b0;
    n_records++;
    case ($urandom_range(9))
      0:       usec = USEC_MAX;
      1:       usec = USEC_MAX + 1;
      2:       usec = $urandom | 32'h0010_0000;
      default: usec = $urandom_range(USEC_MAX);
    endcase
    // Lengths around the limit decide keep or drop; large ones get cut
    case ($urandom_range(7))
      0:       orig = '0;
      1:       orig = 32'(cur_limit);
      2:       orig = 32'(cur_limit) + 1;
      3:       orig = $urandom;
      default: orig = $urandom_range(1, SHORT_PAYLOAD);
    endcase
    incl = ($urandom_range(11) == 0) ? orig ^ (32'd1 << $urandom_range(31)) : orig;
    rh = {32'($urandom), usec, incl, orig};
    for (int i = 0; i <= HDR_LAST; i++)
      send_byte({rh[127 - 8*i -: 8], 1'b0, 3'b000});
    if (usec > USEC_MAX || incl != orig) begin
      send_noise();
      return;
    end
    if (orig > SHORT_PAYLOAD) begin
      // Truncate: the next file's restart cuts this record short
      repeat ($urandom_range(5)) send_byte({8'($urandom), 1'b0, 3'b000});
      return;
    end
    repeat (orig) send_byte({8'($urandom), 1'b0, 3'b000});
    clean = 1'b1;
  endtask

  // One capture file: mostly well formed with random content, sometimes cut
  // short or with a corrupted global header, then its first record.
  task automatic send_file(output bit clean);
    int          cut;
    int          bad_at;
    logic [7:0]  b;
    clean = 1'b0;
    n_files++;
    cut    = ($urandom_range(11) == 0) ? $urandom_range(1, GHDR_LAST) : GHDR_LAST + 1;
    bad_at = ($urandom_range(7) == 0) ? $urandom_range(GHDR_LAST) : -1;
    for (int i = 0; i < cut; i++) begin
      b = pcap_global[i];
      if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      send_byte({b, i == 0, 3'b000});
    end
    if (cut <= GHDR_LAST || bad_at >= 0) begin
      send_noise();
      return;
    end
    send_record(clean);
  endtask

  // Stop offering and wait until every expected result has been popped,
  // then let any byte still inside the block settle.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending_out.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the length limit; only called with the block idle.
  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit  = v;
  endtask

  initial begin
    rst       <= 1'b1;
    push      <= 1'b0;
    item      <= '0;
    row_now   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    cur_limit  = 19'd1000;
    stream_clean = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 76;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_byte(directed_rows[i]);

    // Four limit settings: reset value, zero, 262144 (the snaplen), and a
    // small random value that sits among the short payload lengths. The byte
    // stream runs on across settings while the parser sits at a record boundary.
    items_sent = 0;
    for (int k = 0; k < 4; k++) begin
      wait_drained();
      case (k)
        1: write_limit('0);
        2: begin
          write_limit(LIMIT_TOP);
          send_idle_pct = 76;
          recv_idle_pct = 34;
        end
        3: begin
          write_limit(LIMIT_W'($urandom_range(1, SHORT_PAYLOAD)));
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Stall the receiver while a fresh file's header is pushed at full rate
          stream_clean = 1'b0;
          hold_asks <= hold_asks + 1;
        end
        default: ;
      endcase
      do begin
        if (stream_clean) send_record(stream_clean);
        else send_file(stream_clean);
      end while (items_sent < ITEMS_PER_SETTING * (k + 1));
    end
    wait_drained();

    if (pending_out.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_out.size());
      n_fail++;
    end
    $display("Covered %0d files with %0d records under four length limits and a long stall;",
             n_files, n_records);
    $display("%0d results checked, %0d of them format errors.", n_checked, n_err_expected);
    if (n_fail == 0)
      $display("PASS pcap_record_length_filter");
    else
      $display("FAIL pcap_record_length_filter");
    $finish;
  end

endmodule
